>>> rtl/core/tmbp_pkg.sv
// Shared types and constants for the tempo map beat position unit.
package tmbp_pkg;

   localparam int TIME_W      = 32;
   localparam int BPM_W       = 18;
   localparam int BEATS_W     = 48;
   localparam int COUNT_OUT_W = 7;
   localparam int STATUS_W    = 2;

   // Sum of span_ms * bpm_q8; the spans tile part of [0, now] so it stays below 2^50.
   localparam int ACC_W = TIME_W + BPM_W;

   // beats = floor(sum * 256 / 60000) = floor(sum * 8 / 1875).
   localparam int          PRE_SHIFT  = 3;
   localparam int          DIGIT_W    = 4;
   localparam int          QUO_W      = ((ACC_W + PRE_SHIFT + DIGIT_W - 1) / DIGIT_W) * DIGIT_W;
   localparam int          DIV_STEPS  = QUO_W / DIGIT_W;
   localparam int          DIV_CNT_W  = $clog2(DIV_STEPS + 1);
   localparam int          REM_W      = 12;
   localparam logic [REM_W-1:0] DIVISOR = REM_W'(60000 / 32);

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_QUERY  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED  = 2'd0,
      ST_OVERWRITE = 2'd1,
      ST_FULL      = 2'd2,
      ST_ANSWER    = 2'd3
   } status_code_type;

   typedef enum logic [3:0] {
      OP_NONE      = 4'd0,
      OP_LOAD      = 4'd1,
      OP_INS_START = 4'd2,
      OP_SCAN      = 4'd3,
      OP_SHIFT     = 4'd4,
      OP_PLACE     = 4'd5,
      OP_Q_START   = 4'd6,
      OP_WALK      = 4'd7,
      OP_DIV_LOAD  = 4'd8,
      OP_DIV_STEP  = 4'd9,
      OP_FINISH    = 4'd10
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } ctl_cmd_type;

   typedef struct packed {
      logic empty;
      logic t_zero;
      logic scan_hit;
      logic scan_greater;
      logic scan_done;
      logic full;
      logic shift_done;
      logic q_go;
      logic walk_stop;
      logic pipe_empty;
      logic div_done;
      logic out_free;
   } dp_status_type;

endpackage

>>> rtl/core/tmbp_divider.sv
// Digit-serial divider by the constant 1875, four quotient bits per cycle while step is high.
module tmbp_divider import tmbp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  logic             step,
   input  logic [QUO_W-1:0] dividend,
   output logic [QUO_W-1:0] quotient,
   output logic             done
);

   logic [QUO_W-1:0]     work_ff, work_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;

   // The work register shifts the dividend out at the top while quotient bits enter below.
   always_comb begin
      logic [REM_W-1:0] r;
      logic [QUO_W-1:0] w;
      r       = rem_ff;
      w       = work_ff;
      work_in = work_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      if (load) begin
         work_in = dividend;
         rem_in  = '0;
         cnt_in  = DIV_CNT_W'(DIV_STEPS);
      end else if (step && (cnt_ff != '0)) begin
         for (int b = 0; b < DIGIT_W; b++) begin
            r = {r[REM_W-2:0], w[QUO_W-1]};
            w = {w[QUO_W-2:0], 1'b0};
            if (r >= DIVISOR) begin
               r    = r - DIVISOR;
               w[0] = 1'b1;
            end
         end
         work_in = w;
         rem_in  = r;
         cnt_in  = cnt_ff - DIV_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      work_ff <= work_in;
      rem_ff  <= rem_in;
   end

   assign quotient = work_ff;
   assign done     = (cnt_ff == '0);

endmodule

>>> rtl/core/tmbp_datapath.sv
// Datapath: tempo table memories, search and shift, span multiply-accumulate, result register.
module tmbp_datapath import tmbp_pkg::*; #(
   parameter int MAX_ENTRIES = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_type,
   input  logic [TIME_W-1:0]      req_event_time_ms,
   input  logic [BPM_W-1:0]       req_tempo_bpm_q8,
   input  logic                   csr_write_enable,
   input  logic                   csr_write_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [BEATS_W-1:0]     rsp_beats_q16,
   output logic [COUNT_OUT_W-1:0] rsp_entry_count,
   input  ctl_cmd_type            cmd,
   output dp_status_type          stat
);

   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);

   logic [TIME_W-1:0] time_mem  [MAX_ENTRIES];
   logic [BPM_W-1:0]  tempo_mem [MAX_ENTRIES];

   logic              time_we, tempo_we, rd_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [TIME_W-1:0] wr_time;
   logic [BPM_W-1:0]  wr_tempo;
   logic [TIME_W-1:0] rd_time_ff;
   logic [BPM_W-1:0]  rd_tempo_ff;

   logic                   req_type_ff, req_type_in;
   logic [TIME_W-1:0]      time_ff, time_in;
   logic [BPM_W-1:0]       bpm_ff, bpm_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          idx_ff, idx_in;
   logic [CW-1:0]          pos_ff, pos_in;
   logic [CW-1:0]          wr_idx_ff, wr_idx_in;
   logic                   wr_pend_ff, wr_pend_in;
   status_code_type        status_ff, status_in;
   logic                   qen_ff, qen_in;
   logic                   have_prev_ff, have_prev_in;
   logic [TIME_W-1:0]      prev_time_ff, prev_time_in;
   logic [BPM_W-1:0]       prev_tempo_ff, prev_tempo_in;
   logic [TIME_W-1:0]      span_ff, span_in;
   logic [BPM_W-1:0]       mtempo_ff, mtempo_in;
   logic                   s1_v_ff, s1_v_in;
   logic [ACC_W-1:0]       prod_ff, prod_in;
   logic                   p_v_ff, p_v_in;
   logic [ACC_W-1:0]       acc_ff, acc_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [BEATS_W-1:0]     rsp_beats_ff, rsp_beats_in;
   logic [COUNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;

   logic [CW-1:0]      j_idx;
   logic               last_idx, at_end, hit, greater, stop, full, out_free;
   logic [TIME_W-1:0]  end_time;
   logic [QUO_W-1:0]   quotient;
   logic [BEATS_W-1:0] beats_sat;
   logic               div_done;

   tmbp_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .load     (cmd.op == OP_DIV_LOAD),
      .step     (cmd.op == OP_DIV_STEP),
      .dividend ({{(QUO_W - ACC_W - PRE_SHIFT){1'b0}}, acc_ff, {PRE_SHIFT{1'b0}}}),
      .quotient (quotient),
      .done     (div_done)
   );

   always_ff @(posedge clock) begin
      if (time_we) begin
         time_mem[wr_addr] <= wr_time;
      end
      if (tempo_we) begin
         tempo_mem[wr_addr] <= wr_tempo;
      end
      if (rd_en) begin
         rd_time_ff  <= time_mem[rd_addr];
         rd_tempo_ff <= tempo_mem[rd_addr];
      end
   end

   // Entry held in the read register during scan and walk.
   assign j_idx    = idx_ff - CW'(1);
   assign last_idx = (idx_ff == count_ff);
   assign at_end   = (j_idx == count_ff);
   assign hit      = (rd_time_ff == time_ff);
   assign greater  = (rd_time_ff > time_ff);
   assign stop     = at_end || (rd_time_ff >= time_ff);
   assign end_time = stop ? time_ff : rd_time_ff;
   assign full     = (count_ff == CW'(MAX_ENTRIES));
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign beats_sat = (quotient[QUO_W-1:BEATS_W] != '0) ? {BEATS_W{1'b1}}
                                                         : quotient[BEATS_W-1:0];

   always_comb begin
      time_we       = 1'b0;
      tempo_we      = 1'b0;
      rd_en         = 1'b0;
      wr_addr       = '0;
      rd_addr       = '0;
      wr_time       = time_ff;
      wr_tempo      = bpm_ff;
      req_type_in   = req_type_ff;
      time_in       = time_ff;
      bpm_in        = bpm_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      wr_idx_in     = wr_idx_ff;
      wr_pend_in    = wr_pend_ff;
      status_in     = status_ff;
      have_prev_in  = have_prev_ff;
      prev_time_in  = prev_time_ff;
      prev_tempo_in = prev_tempo_ff;
      span_in       = span_ff;
      mtempo_in     = mtempo_ff;
      qen_in        = csr_write_enable ? csr_write_data : qen_ff;
      // Multiply-accumulate pipeline runs freely behind the walk.
      s1_v_in       = 1'b0;
      p_v_in        = s1_v_ff;
      prod_in       = ACC_W'(span_ff) * ACC_W'(mtempo_ff);
      acc_in        = p_v_ff ? (acc_ff + prod_ff) : acc_ff;

      unique case (cmd.op)
         OP_NONE: begin
         end
         OP_LOAD: begin
            req_type_in = req_type;
            time_in     = req_event_time_ms;
            bpm_in      = req_tempo_bpm_q8;
         end
         OP_INS_START: begin
            if (count_ff == '0) begin
               // Empty table: a time-zero entry comes first.
               time_we   = 1'b1;
               tempo_we  = 1'b1;
               wr_addr   = '0;
               wr_time   = '0;
               count_in  = CW'(1);
               pos_in    = CW'(1);
               status_in = ST_INSERTED;
            end else begin
               rd_en   = 1'b1;
               rd_addr = '0;
               idx_in  = CW'(1);
            end
         end
         OP_SCAN: begin
            if (hit) begin
               tempo_we  = 1'b1;
               wr_addr   = j_idx[AW-1:0];
               status_in = ST_OVERWRITE;
            end else if (greater) begin
               pos_in     = j_idx;
               idx_in     = count_ff;
               wr_pend_in = 1'b0;
               if (full) begin
                  status_in = ST_FULL;
               end
            end else if (!last_idx) begin
               rd_en   = 1'b1;
               rd_addr = idx_ff[AW-1:0];
               idx_in  = idx_ff + CW'(1);
            end else begin
               pos_in = count_ff;
               if (full) begin
                  status_in = ST_FULL;
               end
            end
         end
         OP_SHIFT: begin
            if (wr_pend_ff) begin
               time_we  = 1'b1;
               tempo_we = 1'b1;
               wr_addr  = wr_idx_ff[AW-1:0];
               wr_time  = rd_time_ff;
               wr_tempo = rd_tempo_ff;
            end
            if (idx_ff != pos_ff) begin
               rd_en      = 1'b1;
               rd_addr    = j_idx[AW-1:0];
               wr_idx_in  = idx_ff;
               wr_pend_in = 1'b1;
               idx_in     = j_idx;
            end else begin
               wr_pend_in = 1'b0;
            end
         end
         OP_PLACE: begin
            time_we   = 1'b1;
            tempo_we  = 1'b1;
            wr_addr   = pos_ff[AW-1:0];
            count_in  = count_ff + CW'(1);
            status_in = ST_INSERTED;
         end
         OP_Q_START: begin
            acc_in       = '0;
            status_in    = ST_ANSWER;
            have_prev_in = 1'b0;
            if (qen_ff && (count_ff != '0)) begin
               rd_en   = 1'b1;
               rd_addr = '0;
               idx_in  = CW'(1);
            end
         end
         OP_WALK: begin
            // The previous entry's span ends at this entry's time or at the query time.
            span_in   = end_time - prev_time_ff;
            mtempo_in = prev_tempo_ff;
            s1_v_in   = have_prev_ff;
            if (!stop) begin
               prev_time_in  = rd_time_ff;
               prev_tempo_in = rd_tempo_ff;
               have_prev_in  = 1'b1;
               idx_in        = idx_ff + CW'(1);
               if (!last_idx) begin
                  rd_en   = 1'b1;
                  rd_addr = idx_ff[AW-1:0];
               end
            end
         end
         OP_DIV_LOAD: begin
         end
         OP_DIV_STEP: begin
         end
         OP_FINISH: begin
         end
         default: begin
         end
      endcase

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_beats_in  = rsp_beats_ff;
      rsp_count_in  = rsp_count_ff;
      if ((cmd.op == OP_FINISH) && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_beats_in  = (req_type_ff == REQ_QUERY) ? beats_sat : '0;
         rsp_count_in  = COUNT_OUT_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         wr_pend_ff   <= 1'b0;
         qen_ff       <= 1'b0;
         s1_v_ff      <= 1'b0;
         p_v_ff       <= 1'b0;
         have_prev_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         wr_pend_ff   <= wr_pend_in;
         qen_ff       <= qen_in;
         s1_v_ff      <= s1_v_in;
         p_v_ff       <= p_v_in;
         have_prev_ff <= have_prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_type_ff   <= req_type_in;
      time_ff       <= time_in;
      bpm_ff        <= bpm_in;
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      wr_idx_ff     <= wr_idx_in;
      status_ff     <= status_in;
      prev_time_ff  <= prev_time_in;
      prev_tempo_ff <= prev_tempo_in;
      span_ff       <= span_in;
      mtempo_ff     <= mtempo_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      rsp_status_ff <= rsp_status_in;
      rsp_beats_ff  <= rsp_beats_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_beats_q16   = rsp_beats_ff;
   assign rsp_entry_count = rsp_count_ff;

   assign stat.empty        = (count_ff == '0);
   assign stat.t_zero       = (time_ff == '0);
   assign stat.scan_hit     = hit;
   assign stat.scan_greater = greater;
   assign stat.scan_done    = hit || greater || last_idx;
   assign stat.full         = full;
   assign stat.shift_done   = (idx_ff == pos_ff) && !wr_pend_ff;
   assign stat.q_go         = qen_ff && (count_ff != '0);
   assign stat.walk_stop    = stop;
   assign stat.pipe_empty   = !s1_v_ff && !p_v_ff;
   assign stat.div_done     = div_done;
   assign stat.out_free     = out_free;

endmodule

>>> rtl/core/tmbp_ctrl.sv
// Controller state machine that sequences inserts and queries over the datapath.
module tmbp_ctrl import tmbp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic          req_type,
   output ctl_cmd_type   cmd,
   input  dp_status_type stat
);

   typedef enum logic [9:0] {
      S_IDLE      = 10'b00_0000_0001,
      S_INS_START = 10'b00_0000_0010,
      S_SCAN      = 10'b00_0000_0100,
      S_SHIFT     = 10'b00_0000_1000,
      S_PLACE     = 10'b00_0001_0000,
      S_Q_START   = 10'b00_0010_0000,
      S_WALK      = 10'b00_0100_0000,
      S_DRAIN     = 10'b00_1000_0000,
      S_DIV       = 10'b01_0000_0000,
      S_FIN       = 10'b10_0000_0000
   } ctl_state_type;

   ctl_state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd.op    = OP_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = (req_type == REQ_QUERY) ? S_Q_START : S_INS_START;
            end
         end
         S_INS_START: begin
            cmd.op = OP_INS_START;
            if (stat.empty) begin
               state_in = stat.t_zero ? S_FIN : S_PLACE;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.op = OP_SCAN;
            if (stat.scan_hit) begin
               state_in = S_FIN;
            end else if (stat.scan_done) begin
               if (stat.full) begin
                  state_in = S_FIN;
               end else if (stat.scan_greater) begin
                  state_in = S_SHIFT;
               end else begin
                  state_in = S_PLACE;
               end
            end
         end
         S_SHIFT: begin
            cmd.op = OP_SHIFT;
            if (stat.shift_done) begin
               state_in = S_PLACE;
            end
         end
         S_PLACE: begin
            cmd.op   = OP_PLACE;
            state_in = S_FIN;
         end
         S_Q_START: begin
            cmd.op   = OP_Q_START;
            state_in = stat.q_go ? S_WALK : S_DRAIN;
         end
         S_WALK: begin
            cmd.op = OP_WALK;
            if (stat.walk_stop) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (stat.pipe_empty) begin
               cmd.op   = OP_DIV_LOAD;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.op = OP_DIV_STEP;
            if (stat.div_done) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            cmd.op = OP_FINISH;
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/core/tempo_map_beat_position_unit.sv
// Top level of the tempo map beat position unit: controller plus datapath.
//
// The request channel (req_valid/req_ready) carries one transaction per item:
// req_type selects an insert of a tempo change or a beat position query,
// req_event_time_ms is the change time or the playback time, and
// req_tempo_bpm_q8 is the tempo for inserts. Every request transaction yields
// exactly one transaction on the response channel (rsp_valid/rsp_ready) with
// a status code, the beat count in Q16 and the number of stored entries.
// The csr port writes the single query_enable bit; the user must write it only
// while idle, as the block itself does not enforce this. One item is worked on
// at a time. An insert scans the table to find its slot and then moves any
// later entries up to open it; a query walks the table and then runs the
// constant divider. The single read port of the table memories, one entry per
// cycle, sets both walks.
// A finished response sits in an output register, so the next request is
// accepted while it waits; if the receiver stalls, the following item
// completes and then holds until the register frees up.
// Reset empties the table, clears query_enable and drops any pending response.
module tempo_map_beat_position_unit import tmbp_pkg::*; #(
   parameter int MAX_ENTRIES = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_type,
   input  logic [TIME_W-1:0]      req_event_time_ms,
   input  logic [BPM_W-1:0]       req_tempo_bpm_q8,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [BEATS_W-1:0]     rsp_beats_q16,
   output logic [COUNT_OUT_W-1:0] rsp_entry_count,
   input  logic                   csr_write_enable,
   input  logic                   csr_write_data
);

   ctl_cmd_type   cmd;
   dp_status_type stat;

   // The controller issues one operation per cycle and holds only its state; all other storage lives in the datapath.
   tmbp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .cmd       (cmd),
      .stat      (stat)
   );

   tmbp_datapath #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_type          (req_type),
      .req_event_time_ms (req_event_time_ms),
      .req_tempo_bpm_q8  (req_tempo_bpm_q8),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_beats_q16     (rsp_beats_q16),
      .rsp_entry_count   (rsp_entry_count),
      .cmd               (cmd),
      .stat              (stat)
   );

endmodule

>>> tb/tmbp_scoreboard_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the tempo map beat position unit: tempo table predictor and result check.
package tmbp_tb_pkg;
   import tmbp_pkg::*;

   localparam int TABLE_DEPTH = 64;
   localparam longint unsigned MS_PER_MINUTE = 60000;
   localparam longint unsigned BEATS_CEILING = 64'h0000_FFFF_FFFF_FFFF;

   typedef struct packed {
      status_code_type          status;
      logic [BEATS_W-1:0]       beats;
      logic [COUNT_OUT_W-1:0]   count;
   } tempo_result_type;

   class tempo_map_scoreboard;
      logic [TIME_W-1:0] start_ms [TABLE_DEPTH];
      logic [BPM_W-1:0]  tempo_q8 [TABLE_DEPTH];
      int unsigned       entries;
      bit                beats_enabled;
      tempo_result_type  awaited[$];
      int unsigned       failures;
      int unsigned       status_tally[4];
      int unsigned       nonzero_answers;

      function new();
         entries = 0;
         beats_enabled = 1'b0;
         failures = 0;
         nonzero_answers = 0;
         foreach (status_tally[i]) status_tally[i] = 0;
      endfunction

      function void set_query_enable(bit enable);
         beats_enabled = enable;
      endfunction

      // Opens a slot at pos by moving the later entries up by one.
      function void store_entry(int unsigned pos, logic [TIME_W-1:0] ms, logic [BPM_W-1:0] bpm);
         for (int unsigned k = entries; k > pos; k--) begin
            start_ms[k] = start_ms[k - 1];
            tempo_q8[k] = tempo_q8[k - 1];
         end
         start_ms[pos] = ms;
         tempo_q8[pos] = bpm;
         entries++;
      endfunction

      function status_code_type apply_insert(logic [TIME_W-1:0] ms, logic [BPM_W-1:0] bpm);
         int unsigned pos;
         pos = 0;
         // The first change at a nonzero time also defines the tempo from time zero.
         if (entries == 0 && ms != 0) store_entry(0, '0, bpm);
         for (int unsigned i = 0; i < entries; i++) begin
            if (start_ms[i] == ms) begin
               tempo_q8[i] = bpm;
               return ST_OVERWRITE;
            end
            if (ms > start_ms[i]) pos = i + 1;
         end
         if (entries >= TABLE_DEPTH) return ST_FULL;
         store_entry(pos, ms, bpm);
         return ST_INSERTED;
      endfunction

      // Integrates tempo over [0, now]; the Q8 tempo times 256 gives Q16 beats.
      function logic [BEATS_W-1:0] beats_at(logic [TIME_W-1:0] now);
         longint unsigned acc;
         longint unsigned beats;
         logic [TIME_W-1:0] span;
         if (!beats_enabled) return '0;
         acc = 0;
         for (int unsigned i = 0; i < entries; i++) begin
            if (start_ms[i] >= now) break;
            if (i + 1 == entries || now < start_ms[i + 1]) span = now - start_ms[i];
            else span = start_ms[i + 1] - start_ms[i];
            acc += longint'(span) * longint'(tempo_q8[i]);
         end
         beats = (acc * 256) / MS_PER_MINUTE;
         if (beats > BEATS_CEILING) beats = BEATS_CEILING;
         return beats[BEATS_W-1:0];
      endfunction

      function void note_request(logic kind, logic [TIME_W-1:0] ms, logic [BPM_W-1:0] bpm);
         tempo_result_type want;
         if (kind == REQ_QUERY) begin
            want.status = ST_ANSWER;
            want.beats = beats_at(ms);
         end else begin
            want.status = apply_insert(ms, bpm);
            want.beats = '0;
         end
         want.count = COUNT_OUT_W'(entries);
         awaited.push_back(want);
      endfunction

      function void check_response(logic [STATUS_W-1:0] status, logic [BEATS_W-1:0] beats,
                                   logic [COUNT_OUT_W-1:0] count);
         tempo_result_type want;
         if (awaited.size() == 0) begin
            $error("response with no request waiting for it: status %0d beats %0h count %0d",
                   status, beats, count);
            failures++;
            return;
         end
         want = awaited.pop_front();
         if (status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, status);
            failures++;
         end
         if (beats !== want.beats) begin
            $error("beats_q16 mismatch: expected %0h, got %0h", want.beats, beats);
            failures++;
         end
         if (count !== want.count) begin
            $error("entry_count mismatch: expected %0d, got %0d", want.count, count);
            failures++;
         end
         status_tally[want.status]++;
         if (want.status == ST_ANSWER && want.beats != 0) nonzero_answers++;
      endfunction

      function int unsigned pending();
         return awaited.size();
      endfunction

      function logic [TIME_W-1:0] any_stored_time();
         if (entries == 0) return $urandom;
         return start_ms[$urandom_range(0, entries - 1)];
      endfunction
   endclass

endpackage

>>> tb/tempo_map_beat_position_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the tempo map beat position unit.
module tempo_map_beat_position_unit_tb;
   import tmbp_pkg::*;
   import tmbp_tb_pkg::*;

   // Cycles without any transaction before the run is declared hung. The
   // slowest item is an insert into a nearly full table (scan plus shift of
   // 64 entries) behind the longest sender gap and the longest receiver stall.
   localparam int HANG_LIMIT = 3000;
   // Quiet time after the last response, longer than the slowest insert.
   localparam int SETTLE_CYCLES = 160;
   localparam int RANDOM_PHASES = 6;
   localparam int ITEMS_PER_PHASE = 255;
   localparam int MAX_IDLE = 17;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic                   req_type = REQ_INSERT;
   logic [TIME_W-1:0]      req_event_time_ms = '0;
   logic [BPM_W-1:0]       req_tempo_bpm_q8 = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [STATUS_W-1:0]    rsp_status;
   logic [BEATS_W-1:0]     rsp_beats_q16;
   logic [COUNT_OUT_W-1:0] rsp_entry_count;
   logic                   csr_write_enable = 1'b0;
   logic                   csr_write_data = 1'b0;

   tempo_map_scoreboard sb = new();

   // Each side switches now and then between drawing idle cycles per item and
   // running back to back, so that long gap-free stretches also occur.
   bit          sender_steady = 1'b0;
   bit          receiver_steady = 1'b0;
   int unsigned requests_sent = 0;
   int unsigned enable_writes = 0;
   int unsigned idle_cycles = 0;

   tempo_map_beat_position_unit #(
      .MAX_ENTRIES(TABLE_DEPTH)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_event_time_ms(req_event_time_ms),
      .req_tempo_bpm_q8 (req_tempo_bpm_q8),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_beats_q16    (rsp_beats_q16),
      .rsp_entry_count  (rsp_entry_count),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 0;
   end

   // Presents one request and holds it until the block takes it. Valid is
   // only lowered when an idle gap follows, so a back-to-back request never
   // sees valid dropped and raised in the same time step. The predictor is
   // updated at the edge where the transaction is accepted.
   task automatic send_request(input logic kind, input logic [TIME_W-1:0] ms,
                               input logic [BPM_W-1:0] bpm);
      int unsigned gap;
      gap = sender_steady ? 0 : $urandom_range(0, MAX_IDLE);
      if ($urandom_range(0, 47) == 0) sender_steady = !sender_steady;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_event_time_ms <= ms;
      req_tempo_bpm_q8 <= bpm;
      do @(posedge clock); while (!req_ready);
      sb.note_request(kind, ms, bpm);
      requests_sent++;
   endtask

   // Holds the sender back until every outstanding response has been taken.
   // Waiting for a clock edge after lowering valid keeps a following request
   // from raising it again in the same time step.
   task automatic wait_for_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // The enable bit is only changed with the block idle.
   task automatic write_query_enable(input bit enable);
      wait_for_responses();
      csr_write_enable <= 1'b1;
      csr_write_data <= enable;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.set_query_enable(enable);
      enable_writes++;
   endtask

   // Random traffic aimed at the stored entries: most inserts hit an existing
   // time, so the table fills over several hundred items instead of at once,
   // and queries favor the entry boundaries and their neighbors, where the
   // span limits switch between the next entry and the playback time.
   task automatic send_random_item();
      logic              kind;
      logic [TIME_W-1:0] ms;
      logic [BPM_W-1:0]  bpm;
      int unsigned       pick;
      int unsigned       tempo_pick;
      kind = ($urandom_range(0, 99) < 45) ? REQ_QUERY : REQ_INSERT;
      pick = $urandom_range(0, 99);
      if (kind == REQ_QUERY) begin
         if (pick < 30) ms = sb.any_stored_time();
         else if (pick < 50) begin
            ms = sb.any_stored_time();
            ms = $urandom_range(0, 1) ? ms + 1'b1 : ms - 1'b1;
         end else if (pick < 70) ms = $urandom;
         else if (pick < 90) ms = $urandom_range(0, 300000);
         else if (pick < 95) ms = '0;
         else ms = '1;
      end else begin
         if (pick < 70) ms = sb.any_stored_time();
         else if (pick < 76) ms = $urandom;
         else if (pick < 84) ms = $urandom_range(0, 300000);
         else begin
            ms = sb.any_stored_time();
            ms = $urandom_range(0, 1) ? ms + 1'b1 : ms - 1'b1;
         end
      end
      // Queries carry a tempo too; the block has to ignore it.
      tempo_pick = $urandom_range(0, 99);
      if (tempo_pick < 15) bpm = BPM_W'($urandom);
      else if (tempo_pick < 20) bpm = '0;
      else if (tempo_pick < 25) bpm = '1;
      else bpm = BPM_W'($urandom_range(40 * 256, 250 * 256));
      send_request(kind, ms, bpm);
   endtask

   // Response side: draws a stall per response, then checks the transaction
   // against the oldest prediction at the edge where it is accepted.
   initial begin
      int unsigned stall;
      while (reset) @(posedge clock);
      forever begin
         stall = receiver_steady ? 0 : $urandom_range(0, MAX_IDLE);
         if ($urandom_range(0, 39) == 0) receiver_steady = !receiver_steady;
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         sb.check_response(rsp_status, rsp_beats_q16, rsp_entry_count);
      end
   end

   // Hang detection: any accepted transaction on either channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= HANG_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", HANG_LIMIT);
         $display("tempo_map_beat_position_unit regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Out of reset query_enable is clear, so even a query answers zero.
      send_request(REQ_QUERY, 32'd5000, '0);
      write_query_enable(1'b1);
      // Empty table: nothing to integrate.
      send_request(REQ_QUERY, '1, '0);
      // First change at a nonzero time also creates the entry at time zero.
      send_request(REQ_INSERT, 32'd1000, BPM_W'(120 * 256));
      // Same time again only replaces the tempo, both for a user entry and
      // for the implied one at time zero.
      send_request(REQ_INSERT, 32'd1000, BPM_W'(90 * 256));
      send_request(REQ_INSERT, 32'd0, '1);
      // A change in the middle moves the later entry up; zero tempo allowed.
      send_request(REQ_INSERT, 32'd500, '0);
      send_request(REQ_INSERT, '1, '1);
      send_request(REQ_INSERT, 32'hFFFF_FFFE, BPM_W'(1));
      // Query at time zero lies at, not after, the first entry: zero beats.
      send_request(REQ_QUERY, 32'd0, '1);
      // Queries on and just around the entry boundaries.
      send_request(REQ_QUERY, 32'd500, '0);
      send_request(REQ_QUERY, 32'd750, '0);
      send_request(REQ_QUERY, 32'd1000, '0);
      send_request(REQ_QUERY, 32'd1001, '0);
      send_request(REQ_QUERY, 32'hFFFF_FFFE, '0);
      // The last entry sits at the query time, so its span is empty.
      send_request(REQ_QUERY, '1, '0);
      send_request(REQ_QUERY, 32'h8000_0000, '0);
      send_request(REQ_INSERT, 32'h5555_5555, 18'h2AAAA);
      send_request(REQ_INSERT, 32'hAAAA_AAAA, 18'h15555);
      send_request(REQ_QUERY, '1, '1);
      // With queries disabled the table still takes inserts.
      write_query_enable(1'b0);
      send_request(REQ_QUERY, '1, '0);
      send_request(REQ_INSERT, 32'd2000, BPM_W'(100 * 256));
      write_query_enable(1'b1);
      send_request(REQ_QUERY, '1, '0);

      // Random phases; every third one runs with queries disabled. The table
      // fills during the early phases, after which new times are dropped and
      // existing ones are still overwritten.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_query_enable((phase % 3) != 2);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            send_random_item();
            if ($urandom_range(0, 199) == 0) wait_for_responses();
         end
      end

      wait_for_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d requests and %0d enable writes: %0d new entries, %0d overwrites,",
               requests_sent, enable_writes, sb.status_tally[ST_INSERTED],
               sb.status_tally[ST_OVERWRITE]);
      $display("%0d inserts dropped on a full table, %0d queries (%0d with nonzero beats)",
               sb.status_tally[ST_FULL], sb.status_tally[ST_ANSWER], sb.nonzero_answers);
      if (sb.failures == 0) begin
         $display("tempo_map_beat_position_unit regression: pass");
      end else begin
         $display("tempo_map_beat_position_unit regression: fail");
      end
      $finish;
   end

endmodule
